FILE: rtl/pfd_pkg.sv
// Shared types, constants and helpers for the paletted framebuffer display.
// Depends on nothing. The bus, pixel and top-level files use it through scoped names.
package pfd_pkg;

   // Picture geometry and frame store sizing
   localparam int FRAME_COUNT    = 8;
   localparam int PICTURE_WIDTH  = 64;
   localparam int PICTURE_HEIGHT = 64;
   localparam int PIXEL_SCALE    = 6;

   localparam int FRAME_WORDS = (PICTURE_WIDTH * PICTURE_HEIGHT + 7) / 8;
   localparam int STORE_WORDS     = FRAME_COUNT * FRAME_WORDS;
   localparam int ADDR_W          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam int PX_W            = $clog2(PICTURE_WIDTH);
   localparam int PY_W            = (PICTURE_HEIGHT > 1) ? $clog2(PICTURE_HEIGHT) : 1;
   localparam int IDX_W           = $clog2(PICTURE_WIDTH * PICTURE_HEIGHT);

   // Field widths
   localparam int CMD_W     = 2;
   localparam int OFF_W     = 8;
   localparam int DATA_W    = 32;
   localparam int SX_W      = 10;
   localparam int SY_W      = 9;
   localparam int FRAME_W   = 4;
   localparam int UIDX_W    = 13;
   localparam int PAL_W     = 6;
   localparam int PAL_DEPTH = 16;
   localparam int PAL_IDX_W = 4;
   localparam int CSR_IDX_W = 2;

   // Scaled picture extent, compared against coordinate offsets
   localparam int SPAN_W = 11;
   localparam logic [SPAN_W-1:0] SPAN_X = SPAN_W'(PICTURE_WIDTH * PIXEL_SCALE);
   localparam logic [SPAN_W-1:0] SPAN_Y = SPAN_W'(PICTURE_HEIGHT * PIXEL_SCALE);

   // Division by the scale as multiply by a rounded-up reciprocal
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = 17;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((1 << RECIP_SHIFT) + PIXEL_SCALE - 1) / PIXEL_SCALE);
   localparam int PROD_W = SX_W + RECIP_W;

   localparam logic [FRAME_W:0]   FRAME_LIMIT = (FRAME_W + 1)'(FRAME_COUNT);
   localparam logic [UIDX_W-1:0]  WPF_LIMIT   = UIDX_W'(FRAME_WORDS);

   // Commands
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd2;

   // Register offsets
   localparam logic [OFF_W-1:0] OFF_ID          = 8'd0;
   localparam logic [OFF_W-1:0] OFF_CTRL        = 8'd4;
   localparam logic [OFF_W-1:0] OFF_STATUS      = 8'd8;
   localparam logic [OFF_W-1:0] OFF_UPLOAD      = 8'd12;
   localparam logic [OFF_W-1:0] OFF_STREAM      = 8'd16;
   localparam logic [OFF_W-1:0] OFF_PALETTE     = 8'd64;
   localparam logic [OFF_W-1:0] OFF_PALETTE_END = 8'd128;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PIC_LEFT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIC_TOP   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ID = 2'd2;

   localparam logic [SX_W-1:0]      LEFT_RESET  = 10'd128;
   localparam logic [SY_W-1:0]      TOP_RESET   = 9'd48;
   localparam logic [PAL_IDX_W-1:0] BG_ENTRY    = 4'd9;
   localparam logic [7:0]           COLOR_STEP  = 8'd85;
   localparam logic [DATA_W-1:0]    ALPHA_OPAQUE = 32'hFF00_0000;
   localparam logic [DATA_W-1:0]    STATUS_VALUE = 32'd1;

   // Payload types
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [OFF_W-1:0]  reg_offset;
      logic [DATA_W-1:0] write_data;
      logic [SX_W-1:0]   pos_x;
      logic [SY_W-1:0]   pos_y;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [DATA_W-1:0] pixel_color;
   } rsp_type;

   // Display settings seen by the pixel path
   typedef struct packed {
      logic               display_enable;
      logic [FRAME_W-1:0] shown_frame;
      logic [SX_W-1:0]    pic_left;
      logic [SY_W-1:0]    pic_top;
   } view_type;

   // Frame store write from the upload stream
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } store_wr_type;

   // Coordinate mapping result
   typedef struct packed {
      logic              in_pic;
      logic [ADDR_W-1:0] addr;
      logic [2:0]        nib_sel;
   } map_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP,
      ST_READ,
      ST_DONE
   } state_type;

   // 6-bit RRGGBB to opaque ARGB8888
   function automatic logic [DATA_W-1:0] expand_color(input logic [PAL_W-1:0] rgb);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      r = 8'(rgb[5:4]) * COLOR_STEP;
      g = 8'(rgb[3:2]) * COLOR_STEP;
      b = 8'(rgb[1:0]) * COLOR_STEP;
      return ALPHA_OPAQUE | {8'h00, r, g, b};
   endfunction

endpackage

FILE: rtl/pfd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module pfd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pfd_bus.sv
// Register file: configuration registers, control, upload pointer and palette.
// Depends on pfd_pkg.
module pfd_bus (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr,
   input  logic [pfd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pfd_pkg::DATA_W-1:0]          csr_data,
   input  logic                                bus_wr,
   input  logic [pfd_pkg::OFF_W-1:0]           offset,
   input  logic [pfd_pkg::DATA_W-1:0]          wdata,
   input  logic                                pix_pal_en,
   input  logic [pfd_pkg::PAL_IDX_W-1:0]       pix_pal_idx,
   output logic [pfd_pkg::DATA_W-1:0]          rd_data,
   output logic [pfd_pkg::PAL_W-1:0]           pal_rd_data,
   output pfd_pkg::view_type                   view,
   output pfd_pkg::store_wr_type               store_wr
);

   logic [pfd_pkg::SX_W-1:0]    left_ff, left_in;
   logic [pfd_pkg::SY_W-1:0]    top_ff, top_in;
   logic [pfd_pkg::DATA_W-1:0]  id_ff, id_in;
   logic                        enable_ff, enable_in;
   logic [pfd_pkg::FRAME_W-1:0] shown_ff, shown_in;
   logic [pfd_pkg::FRAME_W-1:0] upframe_ff, upframe_in;
   logic [pfd_pkg::UIDX_W-1:0]  upidx_ff, upidx_in;
   logic [pfd_pkg::PAL_W-1:0]   pal_ff [pfd_pkg::PAL_DEPTH];
   logic [pfd_pkg::PAL_W-1:0]   pal_in [pfd_pkg::PAL_DEPTH];

   logic                          is_palette;
   logic [pfd_pkg::PAL_IDX_W-1:0] pal_sel;
   logic [pfd_pkg::PAL_IDX_W-1:0] pal_rd_idx;
   logic [pfd_pkg::FRAME_W-1:0]   wr_frame;
   logic [pfd_pkg::FRAME_W-1:0]   wr_upframe;
   logic                          stream_ok;

   // Offset decode
   assign is_palette = (offset >= pfd_pkg::OFF_PALETTE) && (offset < pfd_pkg::OFF_PALETTE_END);
   assign pal_sel    = pfd_pkg::PAL_IDX_W'((offset - pfd_pkg::OFF_PALETTE) >> 2);

   // Single palette read port, shared between bus reads and pixel lookups
   assign pal_rd_idx  = pix_pal_en ? pix_pal_idx : pal_sel;
   assign pal_rd_data = pal_ff[pal_rd_idx];

   // Frame numbers out of range fold to frame zero
   assign wr_frame   = ({1'b0, wdata[11:8]} < pfd_pkg::FRAME_LIMIT) ? wdata[11:8] : '0;
   assign wr_upframe = ({1'b0, wdata[19:16]} < pfd_pkg::FRAME_LIMIT) ? wdata[19:16] : '0;
   assign stream_ok  = upidx_ff < pfd_pkg::WPF_LIMIT;

   // Upload stream write into the frame store
   always_comb begin
      store_wr.en   = bus_wr && (offset == pfd_pkg::OFF_STREAM) && stream_ok;
      store_wr.addr = pfd_pkg::ADDR_W'(pfd_pkg::ADDR_W'(upframe_ff)
                      * pfd_pkg::ADDR_W'(pfd_pkg::FRAME_WORDS)
                      + pfd_pkg::ADDR_W'(upidx_ff));
      store_wr.data = wdata;
   end

   // Register read mux
   always_comb begin
      rd_data = '0;
      unique case (offset)
         pfd_pkg::OFF_ID:     rd_data = id_ff;
         pfd_pkg::OFF_CTRL:   rd_data = {20'd0, shown_ff, 7'd0, enable_ff};
         pfd_pkg::OFF_STATUS: rd_data = pfd_pkg::STATUS_VALUE;
         default: begin
            if (is_palette) begin
               rd_data = pfd_pkg::DATA_W'(pal_rd_data);
            end
         end
      endcase
   end

   // Next-state for configuration and bus writes
   always_comb begin
      left_in    = left_ff;
      top_in     = top_ff;
      id_in      = id_ff;
      enable_in  = enable_ff;
      shown_in   = shown_ff;
      upframe_in = upframe_ff;
      upidx_in   = upidx_ff;
      pal_in     = pal_ff;
      if (csr_wr) begin
         unique case (csr_index)
            pfd_pkg::CSR_PIC_LEFT:  left_in = csr_data[pfd_pkg::SX_W-1:0];
            pfd_pkg::CSR_PIC_TOP:   top_in  = csr_data[pfd_pkg::SY_W-1:0];
            pfd_pkg::CSR_DEVICE_ID: id_in   = csr_data;
            default: ;
         endcase
      end
      if (bus_wr) begin
         unique case (offset)
            pfd_pkg::OFF_CTRL: begin
               enable_in = wdata[0];
               shown_in  = wr_frame;
            end
            pfd_pkg::OFF_UPLOAD: begin
               upframe_in = wr_upframe;
               upidx_in   = wdata[pfd_pkg::UIDX_W-1:0];
            end
            pfd_pkg::OFF_STREAM: begin
               if (stream_ok) begin
                  upidx_in = upidx_ff + 1'b1;
               end
            end
            default: begin
               if (is_palette) begin
                  pal_in[pal_sel] = wdata[pfd_pkg::PAL_W-1:0];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= pfd_pkg::LEFT_RESET;
         top_ff     <= pfd_pkg::TOP_RESET;
         id_ff      <= '0;
         enable_ff  <= 1'b0;
         shown_ff   <= '0;
         upframe_ff <= '0;
         upidx_ff   <= '0;
         for (int i = 0; i < pfd_pkg::PAL_DEPTH; i++) begin
            pal_ff[i] <= '0;
         end
      end else begin
         left_ff    <= left_in;
         top_ff     <= top_in;
         id_ff      <= id_in;
         enable_ff  <= enable_in;
         shown_ff   <= shown_in;
         upframe_ff <= upframe_in;
         upidx_ff   <= upidx_in;
         pal_ff     <= pal_in;
      end
   end

   always_comb begin
      view.display_enable = enable_ff;
      view.shown_frame    = shown_ff;
      view.pic_left       = left_ff;
      view.pic_top        = top_ff;
   end

endmodule

FILE: rtl/pfd_pixel.sv
// Three-stage coordinate mapper: screen position to frame store word and nibble.
// Depends on pfd_pkg.
module pfd_pixel (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [pfd_pkg::SX_W-1:0] pos_x,
   input  logic [pfd_pkg::SY_W-1:0] pos_y,
   input  pfd_pkg::view_type        view,
   output pfd_pkg::map_type         map,
   output logic                     map_valid
);

   logic                            v1_ff, v2_ff, v3_ff;
   logic [pfd_pkg::SX_W-1:0]        dx_ff;
   logic [pfd_pkg::SY_W-1:0]        dy_ff;
   logic                            in1_ff, in2_ff, in3_ff;
   logic [pfd_pkg::PX_W-1:0]        px_ff;
   logic [pfd_pkg::PY_W-1:0]        py_ff;
   logic [pfd_pkg::ADDR_W-1:0]      addr_ff;
   logic [2:0]                      nib_ff;

   logic [pfd_pkg::SX_W:0]          diff_x;
   logic [pfd_pkg::SY_W:0]          diff_y;
   logic                            in_pic;
   logic [pfd_pkg::PROD_W-1:0]      prod_x, prod_y;
   logic [pfd_pkg::IDX_W-1:0]       idx;
   logic [pfd_pkg::ADDR_W-1:0]      addr;

   // Stage 1: offset from the margins and bounds check
   assign diff_x = {1'b0, pos_x} - {1'b0, view.pic_left};
   assign diff_y = {1'b0, pos_y} - {1'b0, view.pic_top};
   assign in_pic = !diff_x[pfd_pkg::SX_W] && !diff_y[pfd_pkg::SY_W]
                   && ({1'b0, diff_x[pfd_pkg::SX_W-1:0]} < pfd_pkg::SPAN_X)
                   && ({2'b00, diff_y[pfd_pkg::SY_W-1:0]} < pfd_pkg::SPAN_Y);

   // Stage 2: divide by the scale through the reciprocal
   assign prod_x = pfd_pkg::PROD_W'(dx_ff) * pfd_pkg::PROD_W'(pfd_pkg::RECIP);
   assign prod_y = pfd_pkg::PROD_W'(dy_ff) * pfd_pkg::PROD_W'(pfd_pkg::RECIP);

   // Stage 3: pixel index and word address in the shown frame
   assign idx  = pfd_pkg::IDX_W'(pfd_pkg::IDX_W'(py_ff) * pfd_pkg::IDX_W'(pfd_pkg::PICTURE_WIDTH))
                 + pfd_pkg::IDX_W'(px_ff);
   assign addr = pfd_pkg::ADDR_W'(pfd_pkg::ADDR_W'(view.shown_frame)
                 * pfd_pkg::ADDR_W'(pfd_pkg::FRAME_WORDS))
                 + pfd_pkg::ADDR_W'(idx >> 3);

   // Stage valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Stage payload registers; outside points map to pixel zero
   always_ff @(posedge clock) begin
      if (start) begin
         dx_ff  <= diff_x[pfd_pkg::SX_W-1:0];
         dy_ff  <= diff_y[pfd_pkg::SY_W-1:0];
         in1_ff <= in_pic;
      end
      if (v1_ff) begin
         px_ff  <= in1_ff ? prod_x[pfd_pkg::RECIP_SHIFT +: pfd_pkg::PX_W] : '0;
         py_ff  <= in1_ff ? prod_y[pfd_pkg::RECIP_SHIFT +: pfd_pkg::PY_W] : '0;
         in2_ff <= in1_ff;
      end
      if (v2_ff) begin
         addr_ff <= addr;
         nib_ff  <= idx[2:0];
         in3_ff  <= in2_ff;
      end
   end

   always_comb begin
      map.in_pic  = in3_ff;
      map.addr    = addr_ff;
      map.nib_sel = nib_ff;
   end

   assign map_valid = v3_ff;

endmodule

FILE: rtl/paletted_framebuffer_display.sv
// Paletted framebuffer display: register bus plus pixel colour queries.
// Register items: result captured on acceptance, then loaded into the output
// register. Pixel items first pass the three-stage coordinate mapper, the frame
// store read and the palette lookup. No new request is accepted until the last
// result is in the output register. Reset: synchronous; a clearing pass then
// zeroes all STORE_WORDS (4096) frame store words before the first request.
module paletted_framebuffer_display (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  pfd_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output pfd_pkg::rsp_type              rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pfd_pkg::DATA_W-1:0]    csr_data
);

   pfd_pkg::state_type           state_ff, state_in;
   logic [pfd_pkg::ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   pfd_pkg::rsp_type             res_ff, res_in;
   pfd_pkg::rsp_type             rsp_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_load;

   logic                         accept;
   logic                         bus_wr;
   logic                         pix_start;
   logic [pfd_pkg::DATA_W-1:0]   bus_rd_data;
   logic [pfd_pkg::PAL_W-1:0]    pal_rd_data;
   logic                         pix_pal_en;
   logic [pfd_pkg::PAL_IDX_W-1:0] pix_pal_idx;
   pfd_pkg::view_type            view;
   pfd_pkg::store_wr_type        store_wr;
   pfd_pkg::map_type             map;
   logic                         map_valid;

   logic                         ram_wr_en;
   logic [pfd_pkg::ADDR_W-1:0]   ram_wr_addr;
   logic [pfd_pkg::DATA_W-1:0]   ram_wr_data;
   logic                         ram_rd_en;
   logic [pfd_pkg::DATA_W-1:0]   ram_rd_data;
   logic [pfd_pkg::PAL_IDX_W-1:0] nibble;
   logic [pfd_pkg::DATA_W-1:0]   color;

   // Handshakes
   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == pfd_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign bus_wr    = accept && (req_payload.cmd == pfd_pkg::CMD_WRITE);
   assign pix_start = accept && (req_payload.cmd == pfd_pkg::CMD_PIXEL);

   pfd_bus u_bus (
      .clock       (clock),
      .reset       (reset),
      .csr_wr      (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .bus_wr      (bus_wr),
      .offset      (req_payload.reg_offset),
      .wdata       (req_payload.write_data),
      .pix_pal_en  (pix_pal_en),
      .pix_pal_idx (pix_pal_idx),
      .rd_data     (bus_rd_data),
      .pal_rd_data (pal_rd_data),
      .view        (view),
      .store_wr    (store_wr)
   );

   pfd_pixel u_pixel (
      .clock     (clock),
      .reset     (reset),
      .start     (pix_start),
      .pos_x     (req_payload.pos_x),
      .pos_y     (req_payload.pos_y),
      .view      (view),
      .map       (map),
      .map_valid (map_valid)
   );

   // Frame store write port: clearing pass or upload stream
   always_comb begin
      if (state_ff == pfd_pkg::ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = store_wr.en;
         ram_wr_addr = store_wr.addr;
         ram_wr_data = store_wr.data;
      end
   end

   assign ram_rd_en = (state_ff == pfd_pkg::ST_MAP) && map_valid;

   pfd_ram #(
      .WIDTH (pfd_pkg::DATA_W),
      .DEPTH (pfd_pkg::STORE_WORDS)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (map.addr),
      .rd_data (ram_rd_data)
   );

   // Palette lookup and colour expansion for a pixel
   assign nibble      = ram_rd_data[{map.nib_sel, 2'b00} +: pfd_pkg::PAL_IDX_W];
   assign pix_pal_en  = (state_ff == pfd_pkg::ST_READ);
   assign pix_pal_idx = map.in_pic ? nibble : pfd_pkg::BG_ENTRY;
   assign color       = view.display_enable ? pfd_pkg::expand_color(pal_rd_data) : '0;

   // Output register frees once taken
   assign rsp_load = (state_ff == pfd_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
      unique case (state_ff)
         pfd_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == pfd_pkg::ADDR_W'(pfd_pkg::STORE_WORDS - 1)) begin
               state_in = pfd_pkg::ST_IDLE;
            end
         end
         pfd_pkg::ST_IDLE: begin
            if (accept) begin
               res_in.read_data   = (req_payload.cmd == pfd_pkg::CMD_READ) ? bus_rd_data : '0;
               res_in.pixel_color = '0;
               state_in = pix_start ? pfd_pkg::ST_MAP : pfd_pkg::ST_DONE;
            end
         end
         pfd_pkg::ST_MAP: begin
            if (map_valid) begin
               state_in = pfd_pkg::ST_READ;
            end
         end
         pfd_pkg::ST_READ: begin
            res_in.pixel_color = color;
            state_in = pfd_pkg::ST_DONE;
         end
         pfd_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = pfd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfd_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload registers
   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
